### hdl/clsm_pkg.sv
// shared types and codes of the circular log slot manager
// no dependencies; imported by clsm_ctrl, clsm_datapath and the top level
package clsm_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_COUNT  = 2'd3
    } func_t;

    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_COUNT   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_BYTES = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_BYTES   = 8'd3;

    localparam logic [31:0] BASE_ADDR_RST    = 32'd0;
    localparam logic [15:0] SLOT_COUNT_RST   = 16'd16;
    localparam logic [15:0] HEADER_BYTES_RST = 16'd64;
    localparam logic [15:0] LINE_BYTES_RST   = 16'd64;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 1;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic calc;
        logic load;
    } clsm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } clsm_sts_t;

endpackage

### hdl/circular_log_slot_manager_top.sv
// an input transaction passes the calc registers (index update with slot multiply),
// then the address add into the output register, which waits while the output stalls
// no new transaction is taken while one is being computed; the next one is accepted
// as the previous result loads, and a result may wait in the output register
// reset: rst_n asynchronous active low clears ring indices and loads register defaults
// top level of the circular log slot manager; depends on clsm_pkg, clsm_ctrl,
// clsm_datapath
module circular_log_slot_manager_top #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [clsm_pkg::S_TDATA_W-1:0]   s_tdata,   // age[15:0]
    input  logic [clsm_pkg::S_TUSER_W-1:0]   s_tuser,   // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [clsm_pkg::M_TDATA_W-1:0]   m_tdata,   // slot_index[15:0], slot_addr[47:16],
                                                        // line_count[63:48], dropped_oldest[64]
    output logic [clsm_pkg::M_TUSER_W-1:0]   m_tuser,   // status[0]
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);
    import clsm_pkg::*;

    clsm_cmd_t cmd;
    clsm_sts_t sts;

    assign cfg_ready = 1'b1;

    clsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clsm_datapath #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### hdl/clsm_ctrl.sv
// controller state machine of the circular log slot manager
// depends on clsm_pkg; drives the datapath through clsm_cmd_t
module clsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  clsm_pkg::clsm_sts_t sts,
    output clsm_pkg::clsm_cmd_t cmd
);
    import clsm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && sts.out_free);
        cmd.capture = s_tvalid && s_tready;
        cmd.calc    = (state_reg == ST_CALC);
        cmd.load    = (state_reg == ST_DONE) && sts.out_free;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_CALC;
                end
                else if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_capture_then_calc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.calc)
        else $error("accepted transaction not processed next cycle");

    a_no_accept_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.calc && s_tready))
        else $error("input accepted while computing");

    a_calc_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc |=> (state_reg == ST_DONE))
        else $error("computed transaction not held for output");
`endif

endmodule

### hdl/clsm_datapath.sv
// datapath of the circular log slot manager: config registers, ring indices,
// slot address multiply-add and output register; depends on clsm_pkg
module clsm_datapath #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  clsm_pkg::clsm_cmd_t                    cmd,
    output clsm_pkg::clsm_sts_t                    sts,
    input  logic                                   cfg_valid,
    input  logic [clsm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [31:0]                            cfg_data,
    input  logic [clsm_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic [clsm_pkg::S_TUSER_W-1:0]         s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [clsm_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [clsm_pkg::M_TUSER_W-1:0]         m_tuser
);
    import clsm_pkg::*;

    localparam int IDX_W = (INDEX_WIDTH < 16) ? INDEX_WIDTH : 16;
    localparam int N_W   = IDX_W + 1;
    localparam logic [16:0] CAP = (INDEX_WIDTH >= 16) ? 17'h10000 : (17'd1 << INDEX_WIDTH);

    logic [31:0]      base_addr_reg;
    logic [15:0]      slot_count_reg;
    logic [15:0]      header_bytes_reg;
    logic [15:0]      line_bytes_reg;

    logic [IDX_W-1:0] newest_reg;
    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] newest_next;
    logic [IDX_W-1:0] oldest_next;

    func_t            func_reg;
    logic [15:0]      age_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [31:0]      prod_reg;
    logic [31:0]      prod_next;
    logic             status_reg;
    logic             status_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             addr_en_reg;
    logic             addr_en_next;

    logic             m_tvalid_reg;
    logic             out_status_reg;
    logic [15:0]      out_index_reg;
    logic [31:0]      out_addr_reg;
    logic [15:0]      out_count_reg;
    logic             out_dropped_reg;

    logic [16:0]      n_full;
    logic [N_W-1:0]   n;
    logic [N_W-1:0]   used;
    logic [16:0]      age_ext;
    logic [16:0]      newest_ext;
    logic [16:0]      n_ext;
    logic [16:0]      used_ext;
    logic [16:0]      read_idx;
    logic             full;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                  input logic [N_W-1:0] nn);
        logic [N_W-1:0] inc;
        inc = {1'b0, i} + N_W'(1);
        return (inc >= nn) ? '0 : inc[IDX_W-1:0];
    endfunction

    always_comb
    begin
        if (slot_count_reg < 16'd2)
        begin
            n_full = 17'd2;
        end
        else if ({1'b0, slot_count_reg} > CAP)
        begin
            n_full = CAP;
        end
        else
        begin
            n_full = {1'b0, slot_count_reg};
        end
        n = n_full[N_W-1:0];

        if (newest_reg >= oldest_reg)
        begin
            used = {1'b0, newest_reg} - {1'b0, oldest_reg};
        end
        else
        begin
            used = n - ({1'b0, oldest_reg} - {1'b0, newest_reg});
        end
        full = (used == (n - N_W'(1)));

        age_ext    = {1'b0, age_reg};
        newest_ext = 17'(newest_reg);
        n_ext      = 17'(n);
        used_ext   = 17'(used);
        if (newest_ext >= age_ext)
        begin
            read_idx = newest_ext - age_ext;
        end
        else
        begin
            read_idx = newest_ext + n_ext - age_ext;
        end

        newest_next  = newest_reg;
        oldest_next  = oldest_reg;
        idx_next     = '0;
        status_next  = 1'b0;
        dropped_next = 1'b0;
        addr_en_next = 1'b0;
        case (func_reg)
            FUNC_APPEND:
            begin
                if (full)
                begin
                    oldest_next  = next_idx(oldest_reg, n);
                    dropped_next = 1'b1;
                end
                newest_next  = next_idx(newest_reg, n);
                idx_next     = newest_next;
                addr_en_next = 1'b1;
            end
            FUNC_READ:
            begin
                if ((age_ext >= n_ext) || (age_ext >= used_ext))
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    idx_next     = read_idx[IDX_W-1:0];
                    addr_en_next = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                newest_next = '0;
                oldest_next = '0;
            end
            FUNC_COUNT:
            begin
            end
            default:
            begin
            end
        endcase

        prod_next = {16'b0, 16'(idx_next)} * {16'b0, line_bytes_reg};
    end

    // config registers and ring indices
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg    <= BASE_ADDR_RST;
            slot_count_reg   <= SLOT_COUNT_RST;
            header_bytes_reg <= HEADER_BYTES_RST;
            line_bytes_reg   <= LINE_BYTES_RST;
            newest_reg       <= '0;
            oldest_reg       <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_ADDR:    base_addr_reg <= cfg_data;
                REG_SLOT_COUNT:
                begin
                    slot_count_reg <= cfg_data[15:0];
                    newest_reg     <= '0;
                    oldest_reg     <= '0;
                end
                REG_HEADER_BYTES: header_bytes_reg <= cfg_data[15:0];
                REG_LINE_BYTES:   line_bytes_reg   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
        else if (cmd.calc)
        begin
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func_t'(s_tuser[1:0]);
            age_reg  <= s_tdata[15:0];
        end
        if (cmd.calc)
        begin
            idx_reg     <= idx_next;
            prod_reg    <= prod_next;
            status_reg  <= status_next;
            dropped_reg <= dropped_next;
            addr_en_reg <= addr_en_next;
        end
        if (cmd.load)
        begin
            out_status_reg  <= status_reg;
            out_index_reg   <= 16'(idx_reg);
            out_addr_reg    <= addr_en_reg ?
                               (base_addr_reg + {16'b0, header_bytes_reg} + prod_reg) : 32'd0;
            out_count_reg   <= 16'(used);
            out_dropped_reg <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tuser      = out_status_reg;
    assign m_tdata      = {7'b0, out_dropped_reg, out_count_reg, out_addr_reg, out_index_reg};

`ifndef NO_ASSERTIONS
    a_indices_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, newest_reg} < n) && ({1'b0, oldest_reg} < n))
        else $error("ring index outside slot count");

    a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_dropped_reg) |-> (out_count_reg == 16'(n - N_W'(1))))
        else $error("dropped oldest line but ring not full");

    a_missing_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_status_reg) |->
            ((out_addr_reg == 32'd0) && (out_index_reg == 16'd0) && !out_dropped_reg))
        else $error("missing line result carries a slot");
`endif

endmodule

### tb/sv/testbench.sv
// self-checking testbench of circular_log_slot_manager_top: stream requests in,
// slot results out, a scoreboard class tracks the ring and checks every result
// depends on clsm_pkg and the circular_log_slot_manager_top rtl
`timescale 1ns / 1ps

module testbench;
    import clsm_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    // register indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = 8'hFF;

    typedef struct packed {
        logic        status;
        logic [15:0] slot_index;
        logic [31:0] slot_addr;
        logic [15:0] line_count;
        logic        dropped_oldest;
    } slot_result_t;

    class slot_scoreboard;
        logic [31:0]  base_addr;
        logic [15:0]  slot_count;
        logic [15:0]  header_bytes;
        logic [15:0]  line_bytes;
        logic [15:0]  newest_pos;
        logic [15:0]  oldest_pos;
        slot_result_t expected_q[$];
        int           errors;

        function new();
            base_addr    = BASE_ADDR_RST;
            slot_count   = SLOT_COUNT_RST;
            header_bytes = HEADER_BYTES_RST;
            line_bytes   = LINE_BYTES_RST;
            newest_pos   = '0;
            oldest_pos   = '0;
            errors       = 0;
        endfunction

        function int unsigned ring_size();
            return (slot_count < 2) ? 2 : slot_count;
        endfunction

        function int unsigned lines_used();
            int unsigned n;
            n = ring_size();
            if (newest_pos >= oldest_pos)
                return newest_pos - oldest_pos;
            return n - (oldest_pos - newest_pos);
        endfunction

        function logic [15:0] advance(logic [15:0] idx);
            int unsigned n;
            n = ring_size();
            return (idx + 1 >= n) ? 16'd0 : idx + 16'd1;
        endfunction

        function logic [31:0] slot_address(logic [15:0] idx);
            logic [31:0] hdr;
            logic [31:0] prod;
            hdr  = {16'd0, header_bytes};
            prod = {16'd0, idx} * {16'd0, line_bytes};
            return base_addr + hdr + prod;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_BASE_ADDR:    base_addr = data;
                REG_SLOT_COUNT:
                begin
                    slot_count = data[15:0];
                    newest_pos = '0;
                    oldest_pos = '0;
                end
                REG_HEADER_BYTES: header_bytes = data[15:0];
                REG_LINE_BYTES:   line_bytes = data[15:0];
                default:          ;
            endcase
        endfunction

        function void note_input(func_t op, logic [15:0] age);
            slot_result_t r;
            int unsigned  n;
            int unsigned  pos;
            n = ring_size();
            r = '0;
            case (op)
                FUNC_APPEND:
                begin
                    if (lines_used() == n - 1)
                    begin
                        oldest_pos       = advance(oldest_pos);
                        r.dropped_oldest = 1'b1;
                    end
                    newest_pos   = advance(newest_pos);
                    r.slot_index = newest_pos;
                    r.slot_addr  = slot_address(newest_pos);
                end
                FUNC_READ:
                begin
                    if (age >= n || age >= lines_used())
                        r.status = 1'b1;
                    else
                    begin
                        pos = (newest_pos >= age) ? newest_pos - age : newest_pos + n - age;
                        r.slot_index = pos[15:0];
                        r.slot_addr  = slot_address(pos[15:0]);
                    end
                end
                FUNC_CLEAR:
                begin
                    newest_pos = '0;
                    oldest_pos = '0;
                end
                default: ;
            endcase
            r.line_count = 16'(lines_used());
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser);
            slot_result_t got;
            slot_result_t exp_r;
            got.status         = tuser[0];
            got.slot_index     = tdata[15:0];
            got.slot_addr      = tdata[47:16];
            got.line_count     = tdata[63:48];
            got.dropped_oldest = tdata[64];
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: status %0d idx %0d addr %h",
                             got.status, got.slot_index, got.slot_addr);
                return;
            end
            exp_r = expected_q.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch exp %0d/%0d/%h/%0d/%0d got %0d/%0d/%h/%0d/%0d",
                             exp_r.status, exp_r.slot_index, exp_r.slot_addr,
                             exp_r.line_count, exp_r.dropped_oldest,
                             got.status, got.slot_index, got.slot_addr,
                             got.line_count, got.dropped_oldest);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]            cfg_data;

    slot_scoreboard sb;
    bit             tx_gaps;
    bit             rx_stalls;
    int             cycle_count;

    always #6 clk = ~clk;

    circular_log_slot_manager_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sample all handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready)
                sb.note_input(func_t'(s_tuser), s_tdata);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("** circular_log_slot_manager_top: FAILED **");
            $finish;
        end
    end

    // receiver with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stalls && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_request(func_t op, logic [15:0] age);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= age;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(logic [31:0] base, logic [15:0] slots, logic [15:0] hdr,
                                  logic [15:0] line, bit stray);
        if (stray)
        begin
            write_register(REG_UNUSED_LOW, $urandom);
            write_register(REG_UNUSED_HIGH, $urandom);
        end
        write_register(REG_BASE_ADDR, base);
        write_register(REG_HEADER_BYTES, {16'd0, hdr});
        write_register(REG_LINE_BYTES, {16'd0, line});
        write_register(REG_SLOT_COUNT, {16'($urandom_range(0, 65535)), slots});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, bit pause_mid);
        int          roll;
        int unsigned n;
        logic [15:0] age;
        func_t       op;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                wait_idle();
            n    = sb.ring_size();
            roll = $urandom_range(0, 99);
            if (roll < 48)
                op = FUNC_APPEND;
            else if (roll < 88)
                op = FUNC_READ;
            else if (roll < 90)
                op = FUNC_CLEAR;
            else
                op = FUNC_COUNT;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                age = 16'($urandom_range(0, sb.lines_used()));
            else if (roll < 85)
                age = 16'($urandom);
            else
                age = 16'($urandom_range(0, n));
            push_request(op, age);
        end
    endtask

    initial
    begin : stimulus
        int unsigned ph_slots[8];
        int          ph_items;
        logic [31:0] base;
        logic [15:0] hdr;
        logic [15:0] line;

        sb          = new();
        cycle_count = 0;
        tx_gaps     = 1'b1;
        rx_stalls   = 1'b1;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_COUNT;
        cfg_valid   = 1'b0;
        cfg_index   = REG_BASE_ADDR;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty log at reset defaults
        push_request(FUNC_COUNT, 16'd0);
        push_request(FUNC_READ, 16'd0);
        push_request(FUNC_APPEND, 16'hFFFF);
        push_request(FUNC_APPEND, 16'd0);
        push_request(FUNC_APPEND, 16'd0);
        push_request(FUNC_READ, 16'd0);
        push_request(FUNC_READ, 16'd2);
        push_request(FUNC_READ, 16'd3);
        push_request(FUNC_READ, 16'hFFFF);
        push_request(FUNC_CLEAR, 16'hFFFF);
        push_request(FUNC_COUNT, 16'hFFFF);
        push_request(FUNC_READ, 16'd0);
        wait_idle();

        // slot count below minimum, addresses wrap at 32 bits, stray register indexes
        apply_settings(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        @(negedge clk);
        push_request(FUNC_APPEND, 16'd0);
        push_request(FUNC_APPEND, 16'd0);
        push_request(FUNC_APPEND, 16'd0);
        push_request(FUNC_READ, 16'd0);
        push_request(FUNC_READ, 16'd1);
        push_request(FUNC_READ, 16'd2);
        push_request(FUNC_COUNT, 16'd0);
        push_request(FUNC_CLEAR, 16'd0);
        push_request(FUNC_READ, 16'd0);
        wait_idle();

        ph_slots = '{3, 5, 1, 2, 16, 40, 65535, 0};
        ph_slots[7] = $urandom_range(2, 64);
        for (int p = 0; p < 8; p++)
        begin
            base = (p == 1) ? 32'hFFFF_FFFF : (p == 3) ? 32'd0 : $urandom;
            hdr  = (p == 2) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom);
            line = (p == 2) ? 16'hFFFF : (p == 3) ? 16'd1 : 16'($urandom_range(1, 65535));
            apply_settings(base, 16'(ph_slots[p]), hdr, line, 1'b0);
            @(negedge clk);
            ph_items = (ph_slots[p] == 65535) ? 60 : 130;
            if (p == 7)
            begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            run_random(ph_items, p == 2);
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** circular_log_slot_manager_top: PASSED **");
        else
            $display("** circular_log_slot_manager_top: FAILED **");
        $finish;
    end

endmodule

### files.f
hdl/clsm_pkg.sv
hdl/clsm_ctrl.sv
hdl/clsm_datapath.sv
hdl/circular_log_slot_manager_top.sv
tb/sv/testbench.sv
